/* rtl/adaptive_mode_escalation_controller_defines.svh */
// assertion macros shared by the rtl
`ifndef ADAPTIVE_MODE_ESCALATION_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_MODE_ESCALATION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define AMEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/amec_pkg.sv */
`timescale 1ns / 1ps

package amec_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 16;
  localparam int TMO_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [TMO_W-1:0] TIMEOUT_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    MODE_NOMINAL  = 2'd0,
    MODE_DEGRADED = 2'd1,
    MODE_HIGH     = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTH_FAIL_LIMIT     = 3'd0,
    CFG_REPLAY_LIMIT        = 3'd1,
    CFG_LOSS_HIGH_LIMIT     = 3'd2,
    CFG_LOSS_UNSTABLE_LIMIT = 3'd3,
    CFG_GRACE_SECONDS       = 3'd4,
    CFG_NORMAL_CHUNK_SIZE   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] auth_fail_limit;
    logic [CFG_W-1:0] replay_limit;
    logic [CFG_W-1:0] loss_high_limit;
    logic [CFG_W-1:0] loss_unstable_limit;
    logic [CFG_W-1:0] grace_seconds;
    logic [CFG_W-1:0] normal_chunk_size;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    auth_fail_limit:     16'd5,
    replay_limit:        16'd3,
    loss_high_limit:     16'd19661,
    loss_unstable_limit: 16'd6554,
    grace_seconds:       16'd30,
    normal_chunk_size:   16'd1024
  };

  typedef struct packed {
    mode_t mode;
    logic  changed;
  } mode_upd_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [8:0]  retry_delay;
    logic [15:0] chunk_bytes;
    logic        pad_always;
    logic        jitter_on;
    logic [3:0]  ratchet_every;
  } mode_settings_t;

  localparam logic [3:0]  RETRY_NORMAL   = 4'd3;
  localparam logic [3:0]  RETRY_UNSTABLE = 4'd7;
  localparam logic [3:0]  RETRY_HIGH     = 4'd10;
  localparam logic [8:0]  DELAY_NORMAL   = 9'd100;
  localparam logic [8:0]  DELAY_UNSTABLE = 9'd200;
  localparam logic [8:0]  DELAY_HIGH     = 9'd300;
  localparam logic [15:0] CHUNK_UNSTABLE = 16'd512;
  localparam logic [15:0] CHUNK_HIGH     = 16'd256;
  localparam logic [3:0]  RATCHET_SLOW   = 4'd10;
  localparam logic [3:0]  RATCHET_HIGH   = 4'd1;
  localparam logic        UDP_BACKUP_ON  = 1'b1;

  function automatic mode_settings_t mode_settings(mode_t m, logic [CFG_W-1:0] normal_chunk);
    mode_settings_t s;
    s = '{RETRY_NORMAL, DELAY_NORMAL, normal_chunk, 1'b0, 1'b0, RATCHET_SLOW};
    unique case (m)
      MODE_HIGH: begin
        s = '{RETRY_HIGH, DELAY_HIGH, CHUNK_HIGH, 1'b1, 1'b1, RATCHET_HIGH};
      end
      MODE_DEGRADED: begin
        s = '{RETRY_UNSTABLE, DELAY_UNSTABLE, CHUNK_UNSTABLE, 1'b0, 1'b0, RATCHET_SLOW};
      end
      MODE_NOMINAL: begin
        s = '{RETRY_NORMAL, DELAY_NORMAL, normal_chunk, 1'b0, 1'b0, RATCHET_SLOW};
      end
      default: begin
        s = '{RETRY_NORMAL, DELAY_NORMAL, normal_chunk, 1'b0, 1'b0, RATCHET_SLOW};
      end
    endcase
    return s;
  endfunction

endpackage

/* rtl/amec_cfg_regs.sv */
`timescale 1ns / 1ps

module amec_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amec_pkg::CFG_W-1:0]     cfg_data,
  output amec_pkg::cfg_t                cfg
);
  import amec_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AUTH_FAIL_LIMIT:     cfg_nxt.auth_fail_limit     = cfg_data;
        CFG_REPLAY_LIMIT:        cfg_nxt.replay_limit        = cfg_data;
        CFG_LOSS_HIGH_LIMIT:     cfg_nxt.loss_high_limit     = cfg_data;
        CFG_LOSS_UNSTABLE_LIMIT: cfg_nxt.loss_unstable_limit = cfg_data;
        CFG_GRACE_SECONDS:       cfg_nxt.grace_seconds       = cfg_data;
        CFG_NORMAL_CHUNK_SIZE:   cfg_nxt.normal_chunk_size   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/amec_classify.sv */
`timescale 1ns / 1ps

module amec_classify (
  input  amec_pkg::cfg_t                cfg,
  input  logic [amec_pkg::CNT_W-1:0]    auth_failures,
  input  logic [amec_pkg::CNT_W-1:0]    replays,
  input  logic [amec_pkg::CFG_W-1:0]    loss_rate,
  input  logic [amec_pkg::TMO_W-1:0]    timeout_run,
  output amec_pkg::mode_t               target
);
  import amec_pkg::*;

  logic high_hit;
  logic unstable_hit;

  assign high_hit = (auth_failures >= cfg.auth_fail_limit) ||
                    (replays >= cfg.replay_limit) ||
                    (loss_rate >= cfg.loss_high_limit);
  assign unstable_hit = (loss_rate >= cfg.loss_unstable_limit) ||
                        (timeout_run >= TIMEOUT_LIMIT);

  always_comb begin
    priority if (high_hit) begin
      target = MODE_HIGH;
    end else if (unstable_hit) begin
      target = MODE_DEGRADED;
    end else begin
      target = MODE_NOMINAL;
    end
  end

endmodule

/* rtl/amec_mode_ctrl.sv */
`timescale 1ns / 1ps

module amec_mode_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  amec_pkg::mode_t               target,
  input  logic [amec_pkg::TIME_BITS-1:0] now,
  input  logic [amec_pkg::CFG_W-1:0]     grace_seconds,
  output amec_pkg::mode_upd_t           upd
);
  import amec_pkg::*;
  `include "adaptive_mode_escalation_controller_defines.svh"

  mode_t                current_mode_r;
  mode_t                current_mode_nxt;
  logic                 grace_running_r;
  logic                 grace_running_nxt;
  logic [TIME_BITS-1:0] grace_start_r;
  logic [TIME_BITS-1:0] grace_start_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] grace_ext;
  logic                 changed;

  assign elapsed   = now - grace_start_r;
  assign grace_ext = {{(TIME_BITS-CFG_W){1'b0}}, grace_seconds};

  always_comb begin
    current_mode_nxt  = current_mode_r;
    grace_running_nxt = grace_running_r;
    grace_start_nxt   = grace_start_r;
    changed           = 1'b0;
    priority if (target > current_mode_r) begin
      grace_running_nxt = 1'b0;
      current_mode_nxt  = target;
      changed           = 1'b1;
    end else if (target < current_mode_r) begin
      priority if (!grace_running_r) begin
        grace_running_nxt = 1'b1;
        grace_start_nxt   = now;
      end else if (elapsed >= grace_ext) begin
        current_mode_nxt = target;
        changed          = 1'b1;
      end else begin
        grace_running_nxt = grace_running_r;
      end
    end else begin
      grace_running_nxt = 1'b0;
    end
  end

  assign upd.mode    = current_mode_nxt;
  assign upd.changed = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_mode_r  <= MODE_NOMINAL;
      grace_running_r <= 1'b0;
      grace_start_r   <= '0;
    end else if (fire) begin
      current_mode_r  <= current_mode_nxt;
      grace_running_r <= grace_running_nxt;
      grace_start_r   <= grace_start_nxt;
    end
  end

  `AMEC_ASSERT_NEXT(a_changed_moves_mode, fire && changed,
    current_mode_r != $past(current_mode_r), "mode change flagged but mode held")
  `AMEC_ASSERT_NEXT(a_escalate_stops_timer, fire && (target > current_mode_r),
    !grace_running_r, "grace timer still running after escalation")
  `AMEC_ASSERT_NEXT(a_first_lower_holds, fire && (target < current_mode_r) && !grace_running_r,
    (current_mode_r == $past(current_mode_r)) && grace_running_r,
    "step-down without running grace timer")

endmodule

/* rtl/adaptive_mode_escalation_controller.sv */
`timescale 1ns / 1ps
// an accepted word waits in the input stage register until the result register is free
// throughput: one word per cycle while out_stall is low, set by the input and result registers
// reset: synchronous active-low rst_n restores register defaults,
// normal mode and a stopped grace timer; no clearing pass is needed

module adaptive_mode_escalation_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [amec_pkg::CNT_W-1:0]     in_auth_failures,
  input  logic [amec_pkg::CNT_W-1:0]     in_replays,
  input  logic [amec_pkg::CFG_W-1:0]     in_loss_rate,
  input  logic [amec_pkg::TMO_W-1:0]     in_timeout_run,
  input  logic [amec_pkg::TIME_BITS-1:0] in_now_seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_mode,
  output logic                           out_mode_changed,
  output logic [3:0]                     out_retry_limit,
  output logic [8:0]                     out_retry_delay,
  output logic [15:0]                    out_chunk_bytes,
  output logic                           out_udp_backup,
  output logic                           out_pad_always,
  output logic                           out_jitter_on,
  output logic [3:0]                     out_ratchet_every,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [amec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amec_pkg::CFG_W-1:0]     cfg_data
);
  import amec_pkg::*;
  `include "adaptive_mode_escalation_controller_defines.svh"

  cfg_t cfg;

  // input stage
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [CNT_W-1:0]     s1_auth_r;
  logic [CNT_W-1:0]     s1_replays_r;
  logic [CFG_W-1:0]     s1_loss_r;
  logic [TMO_W-1:0]     s1_tmo_r;
  logic [TIME_BITS-1:0] s1_now_r;

  // result stage
  logic           out_valid_r;
  logic           out_valid_nxt;
  mode_t          out_mode_r;
  logic           out_changed_r;
  mode_settings_t out_set_r;

  logic      in_acc;
  logic      out_free;
  logic      s1_fire;
  mode_t     target;
  mode_upd_t upd;

  amec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  amec_classify u_cls (
    .cfg           (cfg),
    .auth_failures (s1_auth_r),
    .replays       (s1_replays_r),
    .loss_rate     (s1_loss_r),
    .timeout_run   (s1_tmo_r),
    .target        (target)
  );

  amec_mode_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .target        (target),
    .now           (s1_now_r),
    .grace_seconds (cfg.grace_seconds),
    .upd           (upd)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_auth_r    <= in_auth_failures;
      s1_replays_r <= in_replays;
      s1_loss_r    <= in_loss_rate;
      s1_tmo_r     <= in_timeout_run;
      s1_now_r     <= in_now_seconds;
    end
    if (s1_fire) begin
      out_mode_r    <= upd.mode;
      out_changed_r <= upd.changed;
      out_set_r     <= mode_settings(upd.mode, cfg.normal_chunk_size);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = out_mode_r;
  assign out_mode_changed  = out_changed_r;
  assign out_retry_limit   = out_set_r.retry_limit;
  assign out_retry_delay   = out_set_r.retry_delay;
  assign out_chunk_bytes   = out_set_r.chunk_bytes;
  assign out_udp_backup    = UDP_BACKUP_ON;
  assign out_pad_always    = out_set_r.pad_always;
  assign out_jitter_on     = out_set_r.jitter_on;
  assign out_ratchet_every = out_set_r.ratchet_every;

  `AMEC_ASSERT_NEXT(a_fire_fills_out, s1_fire, out_valid_r,
    "input stage moved but result register empty")
  `AMEC_ASSERT_NOW(a_stall_needs_word, in_stall, s1_valid_r && out_valid_r,
    "input stalled without a held word")
  `AMEC_ASSERT_NEXT(a_held_word_kept, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_now_r),
    "input stage word lost while blocked")

endmodule

/* tb/tb_adaptive_mode_escalation_controller.sv */
`timescale 1ns / 1ps

module tb_adaptive_mode_escalation_controller;
  import amec_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int SECOND_REG_SET_ROW = 19;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0]     auth;
    logic [CNT_W-1:0]     replays;
    logic [CFG_W-1:0]     loss;
    logic [TMO_W-1:0]     tmo;
    logic [TIME_BITS-1:0] now;
  } eval_t;

  typedef struct packed {
    mode_t       mode;
    logic        changed;
    logic [3:0]  retry_limit;
    logic [8:0]  retry_delay;
    logic [15:0] chunk_bytes;
    logic        udp_backup;
    logic        pad_always;
    logic        jitter_on;
    logic [3:0]  ratchet_every;
  } ctl_result_t;

  typedef struct {
    eval_t ev;
    bit    typed;
    mode_t mode;
    logic  changed;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CNT_W-1:0]     in_auth_failures;
  logic [CNT_W-1:0]     in_replays;
  logic [CFG_W-1:0]     in_loss_rate;
  logic [TMO_W-1:0]     in_timeout_run;
  logic [TIME_BITS-1:0] in_now_seconds;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_mode;
  logic                 out_mode_changed;
  logic [3:0]           out_retry_limit;
  logic [8:0]           out_retry_delay;
  logic [15:0]          out_chunk_bytes;
  logic                 out_udp_backup;
  logic                 out_pad_always;
  logic                 out_jitter_on;
  logic [3:0]           out_ratchet_every;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit    idle_on;
  bit    drv_typed;
  mode_t drv_mode;
  logic  drv_chg;
  int    rx_hold_left = 0;
  int    cycle_count = 0;
  int    err_count = 0;
  int    words_seen = 0;

  cfg_t                 cfg_shadow;
  mode_t                cur_mode;
  bit                   grace_on;
  logic [TIME_BITS-1:0] grace_t0;
  ctl_result_t          pending_modes[$];

  adaptive_mode_escalation_controller u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ctl_result_t mode_word(mode_t m, logic chg, logic [15:0] chunk);
    ctl_result_t w;
    w.mode = m;
    w.changed = chg;
    w.udp_backup = UDP_BACKUP_ON;
    case (m)
      MODE_HIGH: begin
        w.retry_limit = RETRY_HIGH;
        w.retry_delay = DELAY_HIGH;
        w.chunk_bytes = CHUNK_HIGH;
        w.pad_always = 1'b1;
        w.jitter_on = 1'b1;
        w.ratchet_every = RATCHET_HIGH;
      end
      MODE_DEGRADED: begin
        w.retry_limit = RETRY_UNSTABLE;
        w.retry_delay = DELAY_UNSTABLE;
        w.chunk_bytes = CHUNK_UNSTABLE;
        w.pad_always = 1'b0;
        w.jitter_on = 1'b0;
        w.ratchet_every = RATCHET_SLOW;
      end
      default: begin
        w.retry_limit = RETRY_NORMAL;
        w.retry_delay = DELAY_NORMAL;
        w.chunk_bytes = chunk;
        w.pad_always = 1'b0;
        w.jitter_on = 1'b0;
        w.ratchet_every = RATCHET_SLOW;
      end
    endcase
    return w;
  endfunction

  function automatic ctl_result_t next_mode_word(eval_t e);
    mode_t                tgt;
    logic                 chg;
    logic [TIME_BITS-1:0] elapsed;
    chg = 1'b0;
    if (e.auth >= cfg_shadow.auth_fail_limit || e.replays >= cfg_shadow.replay_limit ||
        e.loss >= cfg_shadow.loss_high_limit) begin
      tgt = MODE_HIGH;
    end else if (e.loss >= cfg_shadow.loss_unstable_limit || e.tmo >= TIMEOUT_LIMIT) begin
      tgt = MODE_DEGRADED;
    end else begin
      tgt = MODE_NOMINAL;
    end
    elapsed = e.now - grace_t0;
    if (tgt > cur_mode) begin
      grace_on = 1'b0;
      cur_mode = tgt;
      chg = 1'b1;
    end else if (tgt < cur_mode) begin
      // first lower word only starts the timer
      if (!grace_on) begin
        grace_on = 1'b1;
        grace_t0 = e.now;
      end else if (elapsed >= {16'd0, cfg_shadow.grace_seconds}) begin
        cur_mode = tgt;
        chg = 1'b1;
      end
    end else begin
      grace_on = 1'b0;
    end
    return mode_word(cur_mode, chg, cfg_shadow.normal_chunk_size);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    if (err_count <= 40) begin
      $display("mismatch word %0d %s: got %0d want %0d", words_seen, what, got, want);
    end
  endtask

  task automatic check_word(ctl_result_t got, ctl_result_t want);
    if (got.mode != want.mode) report_mismatch("mode", got.mode, want.mode);
    if (got.changed != want.changed) report_mismatch("mode_changed", got.changed, want.changed);
    if (got.retry_limit != want.retry_limit) begin
      report_mismatch("retry_limit", got.retry_limit, want.retry_limit);
    end
    if (got.retry_delay != want.retry_delay) begin
      report_mismatch("retry_delay", got.retry_delay, want.retry_delay);
    end
    if (got.chunk_bytes != want.chunk_bytes) begin
      report_mismatch("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
    end
    if (got.udp_backup != want.udp_backup) begin
      report_mismatch("udp_backup", got.udp_backup, want.udp_backup);
    end
    if (got.pad_always != want.pad_always) begin
      report_mismatch("pad_always", got.pad_always, want.pad_always);
    end
    if (got.jitter_on != want.jitter_on) begin
      report_mismatch("jitter_on", got.jitter_on, want.jitter_on);
    end
    if (got.ratchet_every != want.ratchet_every) begin
      report_mismatch("ratchet_every", got.ratchet_every, want.ratchet_every);
    end
  endtask

  // model, scoreboard
  always @(posedge clk) begin : scoreboard
    eval_t       ev;
    ctl_result_t want;
    ctl_result_t got;
    if (!rst_n) begin
      cfg_shadow = CFG_RESET;
      cur_mode = MODE_NOMINAL;
      grace_on = 1'b0;
      grace_t0 = '0;
      pending_modes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AUTH_FAIL_LIMIT:     cfg_shadow.auth_fail_limit = cfg_data;
          CFG_REPLAY_LIMIT:        cfg_shadow.replay_limit = cfg_data;
          CFG_LOSS_HIGH_LIMIT:     cfg_shadow.loss_high_limit = cfg_data;
          CFG_LOSS_UNSTABLE_LIMIT: cfg_shadow.loss_unstable_limit = cfg_data;
          CFG_GRACE_SECONDS:       cfg_shadow.grace_seconds = cfg_data;
          CFG_NORMAL_CHUNK_SIZE:   cfg_shadow.normal_chunk_size = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        ev.auth = in_auth_failures;
        ev.replays = in_replays;
        ev.loss = in_loss_rate;
        ev.tmo = in_timeout_run;
        ev.now = in_now_seconds;
        want = next_mode_word(ev);
        if (drv_typed) want = mode_word(drv_mode, drv_chg, cfg_shadow.normal_chunk_size);
        pending_modes.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.mode = mode_t'(out_mode);
        got.changed = out_mode_changed;
        got.retry_limit = out_retry_limit;
        got.retry_delay = out_retry_delay;
        got.chunk_bytes = out_chunk_bytes;
        got.udp_backup = out_udp_backup;
        got.pad_always = out_pad_always;
        got.jitter_on = out_jitter_on;
        got.ratchet_every = out_ratchet_every;
        if (pending_modes.size() == 0) begin
          report_mismatch("unexpected word, mode", got.mode, 0);
        end else begin
          want = pending_modes.pop_front();
          check_word(got, want);
        end
        words_seen++;
      end
    end
  end

  // result side backpressure bursts
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] under(logic [15:0] lim);
    if (lim == 16'd0) return 16'd0;
    if ($urandom_range(0, 1) == 0) return lim - 16'd1;
    return 16'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [15:0] reach(logic [15:0] lim);
    if ($urandom_range(0, 1) == 0) return lim;
    return 16'($urandom_range(lim, 16'hFFFF));
  endfunction

  function automatic eval_t gen_eval();
    eval_t       e;
    logic [15:0] lu;
    logic [15:0] lh;
    lu = cfg_shadow.loss_unstable_limit;
    lh = cfg_shadow.loss_high_limit;
    e.auth = under(cfg_shadow.auth_fail_limit);
    e.replays = under(cfg_shadow.replay_limit);
    e.loss = under((lu < lh) ? lu : lh);
    e.tmo = 8'($urandom_range(0, 2));
    e.now = '0;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        e.auth = 16'($urandom);
        e.replays = 16'($urandom);
        e.loss = 16'($urandom);
        e.tmo = 8'($urandom);
      end
      3, 4, 5: begin
        if ($urandom_range(0, 1) == 0) e.tmo = 8'($urandom_range(3, 255));
        else e.loss = reach(lu);
      end
      6, 7: e.auth = reach(cfg_shadow.auth_fail_limit);
      8: e.replays = reach(cfg_shadow.replay_limit);
      9: e.loss = reach(lh);
      default: ;
    endcase
    return e;
  endfunction

  function automatic dir_row_t dir_row(logic [15:0] auth, logic [15:0] rep, logic [15:0] loss,
                                       logic [7:0] tmo, logic [31:0] now, bit typed,
                                       mode_t m, logic chg);
    dir_row_t r;
    r.ev = '{auth, rep, loss, tmo, now};
    r.typed = typed;
    r.mode = m;
    r.changed = chg;
    return r;
  endfunction

  task automatic send_eval(eval_t e, bit typed, mode_t m, logic chg);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_auth_failures <= e.auth;
    in_replays <= e.replays;
    in_loss_rate <= e.loss;
    in_timeout_run <= e.tmo;
    in_now_seconds <= e.now;
    drv_typed <= typed;
    drv_mode <= m;
    drv_chg <= chg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_modes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(cfg_t r);
    settle();
    write_reg(REG_UNMAPPED_A, 16'($urandom));
    write_reg(CFG_AUTH_FAIL_LIMIT, r.auth_fail_limit);
    write_reg(CFG_REPLAY_LIMIT, r.replay_limit);
    write_reg(CFG_LOSS_HIGH_LIMIT, r.loss_high_limit);
    write_reg(CFG_LOSS_UNSTABLE_LIMIT, r.loss_unstable_limit);
    write_reg(CFG_GRACE_SECONDS, r.grace_seconds);
    write_reg(CFG_NORMAL_CHUNK_SIZE, r.normal_chunk_size);
    write_reg(REG_UNMAPPED_B, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t             rows[$];
    eval_t                ev;
    cfg_t                 regs;
    logic [TIME_BITS-1:0] t_now;
    logic [TIME_BITS-1:0] step;
    logic [TIME_BITS-1:0] g;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_auth_failures <= '0;
    in_replays <= '0;
    in_loss_rate <= '0;
    in_timeout_run <= '0;
    in_now_seconds <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_AUTH_FAIL_LIMIT;
    cfg_data <= '0;
    idle_on <= 1'b0;
    drv_typed <= 1'b0;
    drv_mode <= MODE_NOMINAL;
    drv_chg <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_on <= 1'b1;

    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd0, 1, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                           1, MODE_HIGH, 1'b1));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd100, 1, MODE_HIGH, 1'b0));
    rows.push_back(dir_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'd101,
                           1, MODE_HIGH, 1'b0));
    // grace boundary, one short then exact
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd200, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd229, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd230, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd3, 32'd231, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd6553, 8'd2, 32'd232, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd3, 16'd0, 8'd0, 32'd233, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd19660, 8'd0, 32'd234, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd19661, 8'd0, 32'd235, 0, MODE_NOMINAL, 1'b0));
    // time wraps while the timer runs
    rows.push_back(dir_row(16'd4, 16'd2, 16'd6554, 8'd0, 32'hFFFF_FFF0,
                           0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd6554, 8'd0, 32'h0000_000D,
                           0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd6554, 8'd0, 32'h0000_000E,
                           0, MODE_NOMINAL, 1'b0));
    // timer kept after step down, second step right away
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'h0000_000F, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd5, 16'd0, 16'd0, 8'd0, 32'd20, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd21, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd255, 32'd60, 0, MODE_NOMINAL, 1'b0));
    // zero grace and zero unstable loss limit, other limits at maximum
    rows.push_back(dir_row(16'hFFFF, 16'd0, 16'd0, 8'd0, 32'd61, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd62, 0, MODE_NOMINAL, 1'b0));
    rows.push_back(dir_row(16'd0, 16'd0, 16'd0, 8'd0, 32'd62, 0, MODE_NOMINAL, 1'b0));

    for (int i = 0; i < rows.size(); i++) begin
      if (i == SECOND_REG_SET_ROW) begin
        regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        load_regs(regs);
      end
      send_eval(rows[i].ev, rows[i].typed, rows[i].mode, rows[i].changed);
    end

    t_now = 32'd62;
    for (int p = 0; p < RAND_PHASES; p++) begin
      regs = CFG_RESET;
      if (p != 0) begin
        case ($urandom_range(0, 5))
          0: regs.auth_fail_limit = 16'd0;
          1: regs.auth_fail_limit = 16'hFFFF;
          default: regs.auth_fail_limit = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 5))
          0: regs.replay_limit = 16'd0;
          1: regs.replay_limit = 16'hFFFF;
          default: regs.replay_limit = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 5))
          0: regs.loss_high_limit = 16'd0;
          1: regs.loss_high_limit = 16'hFFFF;
          default: regs.loss_high_limit = 16'($urandom_range(8000, 40000));
        endcase
        case ($urandom_range(0, 5))
          0: regs.loss_unstable_limit = 16'd0;
          1: regs.loss_unstable_limit = 16'hFFFF;
          default: regs.loss_unstable_limit = 16'($urandom_range(1000, 12000));
        endcase
        case ($urandom_range(0, 5))
          0: regs.grace_seconds = 16'd0;
          1: regs.grace_seconds = 16'hFFFF;
          default: regs.grace_seconds = 16'($urandom_range(1, 60));
        endcase
        case ($urandom_range(0, 5))
          0: regs.normal_chunk_size = 16'd0;
          1: regs.normal_chunk_size = 16'd1;
          2: regs.normal_chunk_size = 16'hFFFF;
          default: regs.normal_chunk_size = 16'($urandom);
        endcase
      end
      load_regs(regs);
      idle_on <= (p != RAND_PHASES - 1);
      g = {16'd0, cfg_shadow.grace_seconds};
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p != RAND_PHASES - 1 && k % 50 == 25) idle_on <= ($urandom_range(0, 3) != 0);
        ev = gen_eval();
        case ($urandom_range(0, 9))
          0: step = '0;
          1: step = g;
          2: step = g + 1;
          3: step = (g == 0) ? '0 : g - 1;
          4: step = $urandom;
          5: step = $urandom_range(0, g);
          default: step = $urandom_range(1, 3);
        endcase
        t_now = t_now + step;
        ev.now = t_now;
        send_eval(ev, 1'b0, MODE_NOMINAL, 1'b0);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
